FILE: hw/rtl/iirll_pkg.sv
// ----------------------------------------------------------------------------
// iirll_pkg
// Shared constants for the lattice-ladder filter: orders, widths, function codes.
// ----------------------------------------------------------------------------
`default_nettype none

package iirll_pkg;

  localparam int MAX_ORDER = 16;

  // Address widths of the coefficient and error stores.
  localparam int RW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int LW = $clog2(MAX_ORDER + 1);
  // Count width, wide enough to hold MAX_ORDER + 1.
  localparam int CW = $clog2(MAX_ORDER + 2);

  localparam int COEF_W = 18;
  localparam int ERR_W  = 24;
  localparam int SMP_W  = 16;
  localparam int PROD_W = COEF_W + ERR_W;
  localparam int ACC_W  = PROD_W + 6;
  localparam int SHIFT  = 14;
  localparam int RND_W  = PROD_W - SHIFT;

  localparam logic [4:0] ORDER_RESET = 5'd16;

  localparam logic [1:0] FUNC_SAMPLE = 2'd0;
  localparam logic [1:0] FUNC_REFL   = 2'd1;
  localparam logic [1:0] FUNC_LADDER = 2'd2;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [ERR_W-1:0]  err_t;

endpackage

`default_nettype wire

FILE: hw/rtl/iirll_ram.sv
// ----------------------------------------------------------------------------
// iirll_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module iirll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/iir_lattice_ladder_filter_top.sv
// ----------------------------------------------------------------------------
// iir_lattice_ladder_filter_top
// Fixed-point all-pole lattice filter with ladder output taps.
// ----------------------------------------------------------------------------
// Each input word either writes one reflection coefficient (func 1), writes
// one ladder coefficient (func 2) or filters one sample (func 0); func 3 is
// dropped. Coefficient writes give no output word. A sample of order P runs
// three passes through one shared multiplier: the forward errors down the
// lattice, the new backward errors up the lattice, and the ladder-weighted
// sum. Each pass issues one stage a cycle, drains the read and product
// registers and then switches to the next pass; the ladder pass has one
// stage more. A final state loads the output register and waits for as long
// as the previous output word is still not taken; the next sample is
// accepted only after it. All state sits in small memories with one write
// and one read port; the reflection, ladder and delay stores carry a valid
// bit per entry so reset clears them at once and no clearing pass is needed.
// The input side accepts a new word while the last output word still waits
// to be taken.
// The order register may be written only while no sample is in progress.
// ----------------------------------------------------------------------------
`default_nettype none

module iir_lattice_ladder_filter_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [4:0]                    cfg_wr_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    in_func,
  input  wire logic [4:0]                    in_coef_index,
  input  wire logic signed [iirll_pkg::COEF_W-1:0] in_coef_value,
  input  wire logic signed [iirll_pkg::SMP_W-1:0]  in_sample,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [iirll_pkg::SMP_W-1:0] out_filtered,
  output logic                               out_saturated
);

  import iirll_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_P1   = 3'd1;
  localparam logic [2:0] S_P2   = 3'd2;
  localparam logic [2:0] S_P3   = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  localparam logic signed [ERR_W:0] ERR_HI = (ERR_W+1)'((1 << (ERR_W-1)) - 1);
  localparam logic signed [ERR_W:0] ERR_LO = -(ERR_W+1)'(1 << (ERR_W-1));

  logic [2:0]    state_r, state_nxt;
  logic [4:0]    order_r;
  logic [CW-1:0] p_r, p_nxt;
  logic [LW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] left_r, left_nxt;
  logic          v1_r, v2_r;
  logic [LW-1:0] idx1_r, idx2_r;
  err_t          f_run_r, f_run_nxt;
  logic          sat_r, sat_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [PROD_W-1:0] prod_r;
  err_t          add_r;
  logic          out_valid_r;
  logic signed [SMP_W-1:0] out_filtered_r;
  logic          out_saturated_r;

  // Per-entry valid bits: a never-written entry reads as zero.
  logic [MAX_ORDER-1:0] rv_r;
  logic [MAX_ORDER:0]   lv_r, bv_r;
  logic                 rv_q_r, lv_q_r, bv_q_r;

  logic          accept, issue, pass_done;
  logic          refl_we, lad_we, fwd_we, back_we, back_wr0;
  logic [LW-1:0] back_waddr;
  err_t          back_wdata;
  coef_t         refl_rd, lad_rd;
  err_t          fwd_rd, back_rd;
  coef_t         coef_op;
  err_t          err_op;
  logic signed [PROD_W-1:0] prod_c;
  logic signed [PROD_W:0]   prod_rnd;
  logic signed [RND_W-1:0]  rnd_c;
  logic signed [ERR_W+5:0]  upd_c;
  err_t          upd_sat;
  logic          upd_clip;
  logic signed [ACC_W-1:0]  acc_rnd;
  logic signed [ACC_W-SHIFT-1:0] y_c;
  logic signed [SMP_W-1:0] y_sat;
  logic          y_clip;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign issue     = (left_r != '0);
  assign pass_done = !issue && !v1_r && !v2_r;

  assign refl_we = accept && (in_func == FUNC_REFL) && (32'(in_coef_index) < MAX_ORDER);
  assign lad_we  = accept && (in_func == FUNC_LADDER) && (32'(in_coef_index) <= MAX_ORDER);

  // Forward errors are stored in pass one. Pass two writes each new backward
  // error one stage up; the error at stage zero becomes the new backward
  // error at stage zero only once pass two has read the old delay value.
  assign fwd_we     = v2_r && (state_r == S_P1);
  assign back_wr0   = (state_r == S_P2) && pass_done;
  assign back_we    = (v2_r && (state_r == S_P2)) || back_wr0;
  assign back_waddr = v2_r ? idx2_r + LW'(1) : '0;
  assign back_wdata = back_wr0 ? f_run_r : upd_sat;

  iirll_ram #(.WIDTH(COEF_W), .DEPTH(MAX_ORDER)) u_refl (
    .clk, .we(refl_we), .waddr(in_coef_index[RW-1:0]), .wdata(in_coef_value),
    .raddr(cnt_r[RW-1:0]), .rdata(refl_rd)
  );

  iirll_ram #(.WIDTH(COEF_W), .DEPTH(MAX_ORDER+1)) u_ladder (
    .clk, .we(lad_we), .waddr(in_coef_index[LW-1:0]), .wdata(in_coef_value),
    .raddr(cnt_r), .rdata(lad_rd)
  );

  iirll_ram #(.WIDTH(ERR_W), .DEPTH(MAX_ORDER+1)) u_fwd (
    .clk, .we(fwd_we), .waddr(idx2_r), .wdata(upd_sat),
    .raddr(cnt_r), .rdata(fwd_rd)
  );

  iirll_ram #(.WIDTH(ERR_W), .DEPTH(MAX_ORDER+1)) u_back (
    .clk, .we(back_we), .waddr(back_waddr), .wdata(back_wdata),
    .raddr(cnt_r), .rdata(back_rd)
  );

  // Operand selection in the cycle after the read is issued.
  always_comb begin
    if (state_r == S_P3) begin
      coef_op = lv_q_r ? lad_rd : '0;
    end else begin
      coef_op = rv_q_r ? refl_rd : '0;
    end
    if (state_r == S_P2) begin
      err_op = fwd_rd;
    end else begin
      err_op = bv_q_r ? back_rd : '0;
    end
    prod_c = coef_op * err_op;
  end

  // Rounding and saturating update on the registered product.
  always_comb begin
    prod_rnd = (PROD_W+1)'(prod_r) + (PROD_W+1)'(1 << (SHIFT-1));
    rnd_c    = prod_rnd[PROD_W-1:SHIFT];
    if (state_r == S_P1) begin
      upd_c = (ERR_W+6)'(f_run_r) - (ERR_W+6)'(rnd_c);
    end else begin
      upd_c = (ERR_W+6)'(add_r) + (ERR_W+6)'(rnd_c);
    end
    upd_clip = 1'b0;
    if (upd_c > (ERR_W+6)'(ERR_HI)) begin
      upd_sat  = ERR_HI[ERR_W-1:0];
      upd_clip = 1'b1;
    end else if (upd_c < (ERR_W+6)'(ERR_LO)) begin
      upd_sat  = ERR_LO[ERR_W-1:0];
      upd_clip = 1'b1;
    end else begin
      upd_sat = upd_c[ERR_W-1:0];
    end
  end

  // Output rounding and 16-bit saturation.
  always_comb begin
    acc_rnd = acc_r + ACC_W'(1 << (SHIFT-1));
    y_c     = acc_rnd[ACC_W-1:SHIFT];
    y_clip  = 1'b0;
    if (y_c > (ACC_W-SHIFT)'((1 << (SMP_W-1)) - 1)) begin
      y_sat  = {1'b0, {(SMP_W-1){1'b1}}};
      y_clip = 1'b1;
    end else if (y_c < -(ACC_W-SHIFT)'(1 << (SMP_W-1))) begin
      y_sat  = {1'b1, {(SMP_W-1){1'b0}}};
      y_clip = 1'b1;
    end else begin
      y_sat = y_c[SMP_W-1:0];
    end
  end

  // Pass sequencing.
  always_comb begin
    state_nxt = state_r;
    p_nxt     = p_r;
    cnt_nxt   = cnt_r;
    left_nxt  = left_r;
    f_run_nxt = f_run_r;
    sat_nxt   = sat_r;
    acc_nxt   = acc_r;

    if (v2_r) begin
      if (state_r == S_P1) begin
        f_run_nxt = upd_sat;
      end
      if (state_r == S_P3) begin
        acc_nxt = acc_r + ACC_W'(prod_r);
      end else begin
        sat_nxt = sat_r | upd_clip;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (accept && (in_func == FUNC_SAMPLE)) begin
          if (order_r == '0) begin
            p_nxt = CW'(1);
          end else if (32'(order_r) > MAX_ORDER) begin
            p_nxt = CW'(MAX_ORDER);
          end else begin
            p_nxt = CW'(order_r);
          end
          cnt_nxt   = LW'(p_nxt - CW'(1));
          left_nxt  = p_nxt;
          f_run_nxt = ERR_W'(in_sample);
          sat_nxt   = 1'b0;
          acc_nxt   = '0;
          state_nxt = S_P1;
        end
      end
      S_P1: begin
        if (issue) begin
          left_nxt = left_r - CW'(1);
          if (cnt_r != '0) begin
            cnt_nxt = cnt_r - LW'(1);
          end
        end else if (pass_done) begin
          cnt_nxt   = '0;
          left_nxt  = p_r;
          state_nxt = S_P2;
        end
      end
      S_P2: begin
        if (issue) begin
          left_nxt = left_r - CW'(1);
          cnt_nxt  = cnt_r + LW'(1);
        end else if (pass_done) begin
          cnt_nxt   = '0;
          left_nxt  = p_r + CW'(1);
          state_nxt = S_P3;
        end
      end
      S_P3: begin
        if (issue) begin
          left_nxt = left_r - CW'(1);
          cnt_nxt  = cnt_r + LW'(1);
        end else if (pass_done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      order_r     <= ORDER_RESET;
      left_r      <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      rv_r        <= '0;
      lv_r        <= '0;
      bv_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      left_r  <= left_nxt;
      v1_r    <= issue && (state_r != S_IDLE) && (state_r != S_FIN);
      v2_r    <= v1_r;
      if (cfg_wr_en) begin
        order_r <= cfg_wr_data;
      end
      if (refl_we) begin
        rv_r[in_coef_index[RW-1:0]] <= 1'b1;
      end
      if (lad_we) begin
        lv_r[in_coef_index[LW-1:0]] <= 1'b1;
      end
      if (back_we) begin
        bv_r[back_waddr] <= 1'b1;
      end
      if ((state_r == S_FIN) && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    p_r     <= p_nxt;
    cnt_r   <= cnt_nxt;
    f_run_r <= f_run_nxt;
    sat_r   <= sat_nxt;
    acc_r   <= acc_nxt;
    idx1_r  <= cnt_r;
    idx2_r  <= idx1_r;
    rv_q_r  <= rv_r[cnt_r[RW-1:0]];
    lv_q_r  <= lv_r[cnt_r];
    bv_q_r  <= bv_r[cnt_r];
    prod_r  <= prod_c;
    add_r   <= bv_q_r ? back_rd : '0;
    if ((state_r == S_FIN) && (!out_valid_r || out_ready)) begin
      out_filtered_r  <= y_sat;
      out_saturated_r <= sat_r | y_clip;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_filtered  = out_filtered_r;
  assign out_saturated = out_saturated_r;

endmodule

`default_nettype wire

FILE: bench/iir_lattice_ladder_filter_checker.sv
// ----------------------------------------------------------------------------
// iir_lattice_ladder_filter_checker
// Watches the input and output channels of the lattice-ladder filter, keeps
// its own copy of the coefficient and delay state, predicts each output word
// and compares it with what the block returns.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module iir_lattice_ladder_filter_checker
  import iirll_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [4:0]        cfg_wr_data,
  input  wire logic              in_valid,
  input  wire logic              in_ready,
  input  wire logic [1:0]        in_func,
  input  wire logic [4:0]        in_coef_index,
  input  wire logic signed [COEF_W-1:0] in_coef_value,
  input  wire logic signed [SMP_W-1:0]  in_sample,
  input  wire logic              out_valid,
  input  wire logic              out_ready,
  input  wire logic signed [SMP_W-1:0]  out_filtered,
  input  wire logic              out_saturated,
  output int                     fail_count,
  output int                     pending_words
);

  typedef struct packed {
    logic signed [SMP_W-1:0] filtered;
    logic                    saturated;
  } filt_word_t;

  logic [4:0]            order_reg;
  logic signed [63:0]    refl_coefs [MAX_ORDER];
  logic signed [63:0]    ladder_coefs [MAX_ORDER+1];
  logic signed [63:0]    delay_errs [MAX_ORDER+1];
  filt_word_t            expected_words [$];

  assign pending_words = expected_words.size();

  function automatic logic signed [63:0] round_q14(input logic signed [63:0] v);
    return (v + 64'sd8192) >>> SHIFT;
  endfunction

  function automatic logic signed [63:0] clamp(input logic signed [63:0] v,
      input logic signed [63:0] lo, input logic signed [63:0] hi, inout logic hit);
    if (v > hi) begin
      hit = 1'b1;
      return hi;
    end
    if (v < lo) begin
      hit = 1'b1;
      return lo;
    end
    return v;
  endfunction

  // Runs one sample through the lattice, updates the delay line and returns
  // the output word.
  function automatic filt_word_t filter_sample(input logic signed [SMP_W-1:0] x);
    logic signed [63:0] fwd [MAX_ORDER+1];
    logic signed [63:0] bwd [MAX_ORDER+1];
    logic signed [63:0] acc;
    logic               hit;
    int                 p;
    filt_word_t         w;
    hit = 1'b0;
    p = order_reg;
    if (p < 1) p = 1;
    if (p > MAX_ORDER) p = MAX_ORDER;
    fwd[p] = x;
    for (int m = p - 1; m >= 0; m--)
      fwd[m] = clamp(fwd[m+1] - round_q14(refl_coefs[m] * delay_errs[m]),
                     -64'sd8388608, 64'sd8388607, hit);
    bwd[0] = fwd[0];
    for (int m = 0; m < p; m++)
      bwd[m+1] = clamp(delay_errs[m] + round_q14(refl_coefs[m] * fwd[m]),
                       -64'sd8388608, 64'sd8388607, hit);
    acc = 0;
    for (int m = 0; m <= p; m++)
      acc += bwd[m] * ladder_coefs[m];
    acc = clamp(round_q14(acc), -64'sd32768, 64'sd32767, hit);
    for (int m = 0; m <= p; m++)
      delay_errs[m] = bwd[m];
    w.filtered = acc[SMP_W-1:0];
    w.saturated = hit;
    return w;
  endfunction

  always @(posedge clk) begin
    filt_word_t want;
    if (!rst_n) begin
      order_reg <= ORDER_RESET;
      for (int i = 0; i < MAX_ORDER; i++) refl_coefs[i] = 0;
      for (int i = 0; i <= MAX_ORDER; i++) begin
        ladder_coefs[i] = 0;
        delay_errs[i] = 0;
      end
      expected_words.delete();
      fail_count <= 0;
    end else begin
      if (cfg_wr_en)
        order_reg <= cfg_wr_data;
      if (in_valid && in_ready) begin
        case (in_func)
          FUNC_REFL: begin
            if (in_coef_index < MAX_ORDER) refl_coefs[in_coef_index] = in_coef_value;
          end
          FUNC_LADDER: begin
            if (in_coef_index <= MAX_ORDER) ladder_coefs[in_coef_index] = in_coef_value;
          end
          FUNC_SAMPLE: begin
            expected_words.push_back(filter_sample(in_sample));
          end
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected output word: filtered %0d saturated %0b",
                     out_filtered, out_saturated);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_words.pop_front();
          if (want.filtered !== out_filtered || want.saturated !== out_saturated) begin
            if (fail_count < 10)
              $display("mismatch: expected %0d/%0b, got %0d/%0b", want.filtered,
                       want.saturated, out_filtered, out_saturated);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

FILE: bench/iir_lattice_ladder_filter_top_tb.sv
// ----------------------------------------------------------------------------
// iir_lattice_ladder_filter_top_tb
// Drives coefficient writes, samples and order changes into the lattice-ladder
// filter with random gaps and back-pressure; the checker judges every word.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module iir_lattice_ladder_filter_top_tb;
  import iirll_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  // Writes and drops give no word, so we wait this long after the last
  // word before touching the order register.
  localparam int SETTLE_CYCLES = 80;
  // The function code that the block ignores.
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [4:0] cfg_wr_data;
  logic in_valid;
  logic in_ready;
  logic [1:0] in_func;
  logic [4:0] in_coef_index;
  logic signed [COEF_W-1:0] in_coef_value;
  logic signed [SMP_W-1:0] in_sample;
  logic out_valid;
  logic out_ready;
  logic signed [SMP_W-1:0] out_filtered;
  logic out_saturated;
  int fail_count;
  int pending_words;
  int cycle_count = 0;
  bit stall_free;

  iir_lattice_ladder_filter_top dut (.*);

  iir_lattice_ladder_filter_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A run that hangs is a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one, with calm stretches between.
  function automatic int pick_gap();
    if (stall_free) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // The receiver holds ready low for random stretches.
  initial begin
    int gap;
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Offers one word and holds it until the block takes it.
  task automatic send_word(input logic [1:0] func, input logic [4:0] index,
                           input logic signed [COEF_W-1:0] value,
                           input logic signed [SMP_W-1:0] smp);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= func;
    in_coef_index <= index;
    in_coef_value <= value;
    in_sample <= smp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Lets the block drain, then writes the order register while it is idle.
  task automatic set_order(input logic [4:0] order);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= order;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Random coefficients stay small most of the time so the filter is not
  // pinned at its rails, with full-range values now and then.
  function automatic logic signed [COEF_W-1:0] rand_coef();
    if ($urandom_range(0, 7) == 0) return COEF_W'($urandom);
    return $signed(COEF_W'($urandom_range(0, 16383))) - 18'sd8192;
  endfunction

  initial begin
    logic [4:0] orders [6];
    int pick;
    orders = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd4, 5'd9};
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_func = FUNC_SAMPLE;
    in_coef_index = '0;
    in_coef_value = '0;
    in_sample = '0;
    stall_free = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: a sample through an all-zero filter, then extreme coefficients,
    // out-of-range indexes, the unused function code and extreme samples.
    send_word(FUNC_SAMPLE, 5'd0, '0, 16'sh7fff);
    send_word(FUNC_LADDER, 5'd0, 18'sh1ffff, '0);
    send_word(FUNC_LADDER, 5'd16, 18'sh20000, '0);
    send_word(FUNC_LADDER, 5'd17, 18'sh04000, '0);
    send_word(FUNC_LADDER, 5'd31, 18'sh04000, '0);
    send_word(FUNC_REFL, 5'd0, 18'sh20000, '0);
    send_word(FUNC_REFL, 5'd15, 18'sh1ffff, '0);
    send_word(FUNC_REFL, 5'd16, 18'sh01000, '0);
    send_word(FUNC_REFL, 5'd31, 18'sh01000, '0);
    send_word(FUNC_SPARE, 5'd31, 18'sh3ffff, 16'sh7fff);
    send_word(FUNC_SAMPLE, 5'd31, 18'sh3ffff, 16'sh8000);
    send_word(FUNC_SAMPLE, 5'd0, '0, 16'sh7fff);
    send_word(FUNC_SAMPLE, 5'd0, '0, 16'sh7fff);
    send_word(FUNC_SAMPLE, 5'd0, '0, 16'sh0000);
    send_word(FUNC_SAMPLE, 5'd0, '0, 16'sh8000);
    send_word(FUNC_SAMPLE, 5'd0, '0, 16'shffff);

    // Random phases, each at its own order, extremes and out-of-range values
    // among them. Every phase reloads all coefficients and then filters.
    for (int ph = 0; ph < 6; ph++) begin
      set_order(orders[ph]);
      stall_free = (ph == 2);
      for (int i = 0; i < 16; i++)
        send_word(FUNC_REFL, i[4:0], rand_coef(), SMP_W'($urandom));
      for (int i = 0; i <= 16; i++)
        send_word(FUNC_LADDER, i[4:0], rand_coef(), SMP_W'($urandom));
      for (int n = 0; n < 40; n++) begin
        pick = $urandom_range(0, 19);
        if (pick == 0)
          send_word(2'($urandom_range(1, 3)), 5'($urandom), COEF_W'($urandom),
                    SMP_W'($urandom));
        else if (pick == 1)
          send_word(FUNC_REFL, 5'($urandom_range(0, 15)), rand_coef(),
                    SMP_W'($urandom));
        else
          send_word(FUNC_SAMPLE, 5'($urandom), COEF_W'($urandom), SMP_W'($urandom));
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
